### design/midi_byte_slot_smoother_unit_assert.svh
// assertion macros for the smoother modules, included by mbss_front
`ifndef MIDI_BYTE_SLOT_SMOOTHER_UNIT_ASSERT_SVH
`define MIDI_BYTE_SLOT_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MBSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbss assertion failed");

// next-cycle implication, checked out of reset
`define MBSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbss assertion failed");

`endif

### design/mbss_pkg.sv
// package: payload types, result flags and constants of the smoother
package mbss_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int PHASE_W        = 3;
  localparam logic [7:0] KEY_MASK_RST = 8'h01;

  typedef struct packed {
    logic       block_start;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       slot_position;
    logic       midi_present;
    logic [7:0] midi_byte;
    logic       overflow;
  } out_word_t;

  typedef struct packed {
    logic slot;
    logic present;
    logic overflow;
  } res_flags_t;

endpackage

### design/mbss_stream_if.sv
// valid/ready channel carrying one word of a given payload type
interface mbss_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/mbss_ring.sv
// byte ring storage: one write port, one registered read port with write bypass
module mbss_ring #(
  parameter int RING_DEPTH = mbss_pkg::RING_DEPTH_DEF,
  localparam int ADDR_W = $clog2(RING_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a byte pushed by the same word may be the one popped
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/mbss_front.sv
// input register, ring pointers and slot phase; drives the ring ports
`include "midi_byte_slot_smoother_unit_assert.svh"
module mbss_front #(
  parameter int RING_DEPTH = mbss_pkg::RING_DEPTH_DEF,
  localparam int PTR_W = $clog2(RING_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mbss_stream_if.sink          in_ch,
  input  logic [7:0]           key_mask,
  input  logic                 down_ready,
  output logic                 fire,
  output mbss_pkg::res_flags_t flags,
  output logic                 wr_en,
  output logic [PTR_W-1:0]     wr_addr,
  output logic [7:0]           wr_data,
  output logic                 rd_en,
  output logic [PTR_W-1:0]     rd_addr
);

  logic                         v1_r;
  mbss_pkg::in_word_t           word_r;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [PTR_W-1:0]             tail_r, tail_nxt;
  logic [mbss_pkg::PHASE_W-1:0] phase_r, phase_nxt, phase_eff;
  logic [PTR_W-1:0]             head_p1, tail_a;
  logic                         push, full_drop, slot, pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign fire        = v1_r && down_ready;
  assign in_ch.ready = !v1_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v1_r <= 1'b1;
    end else if (fire) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word_r <= in_ch.payload;
    end
  end

  always_comb begin
    push      = (word_r.key_byte & key_mask) == key_mask;
    head_p1   = ptr_next(head_r);
    head_nxt  = push ? head_p1 : head_r;
    // ring full: drop the oldest byte
    full_drop = push && (head_p1 == tail_r);
    tail_a    = full_drop ? ptr_next(tail_r) : tail_r;
    phase_eff = word_r.block_start ? '0 : phase_r;
    slot      = (phase_eff == '0);
    pop       = slot && (head_nxt != tail_a);
    tail_nxt  = pop ? ptr_next(tail_a) : tail_a;
    phase_nxt = phase_eff + mbss_pkg::PHASE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      phase_r <= '0;
    end else if (fire) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign wr_en   = fire && push;
  assign wr_addr = head_r;
  assign wr_data = word_r.data_byte;
  assign rd_en   = fire;
  assign rd_addr = tail_a;

  assign flags.slot     = slot;
  assign flags.present  = pop;
  assign flags.overflow = full_drop;

  `MBSS_ASSERT_NEXT(a_stall_holds_state, !fire,
    $stable(head_r) && $stable(tail_r) && $stable(phase_r))
  `MBSS_ASSERT_NEXT(a_no_pop_tail_holds, fire && !pop && !full_drop, $stable(tail_r))
  `MBSS_ASSERT_NEXT(a_block_start_phase, fire && word_r.block_start,
    phase_r == mbss_pkg::PHASE_W'(1))

endmodule

### design/midi_byte_slot_smoother_unit.sv
// top level: key mask register, front stage, byte ring and result register
//
//  channel | dir | payload                                          | taken when
//  in_ch   | in  | block_start, key_byte, data_byte                 | valid & ready
//  out_ch  | out | slot_position, midi_present, midi_byte, overflow | valid & ready
//  cfg_ch  | in  | midi_key_mask (8 bits)                           | valid & ready
//
// one word per cycle while out_ch is not stalled; a result is offered once its word
// has passed the input register and then the result register (with the ring's
// registered read port)
// the ring has one write and one read port; a word reads once and writes at most once
// reset clears valids, pointers and slot phase and sets the key mask to 0x01;
// the ring itself is not cleared
// a stalled result holds and back-pressures the input register; cfg_ch is always ready
module midi_byte_slot_smoother_unit #(
  parameter int RING_DEPTH = mbss_pkg::RING_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mbss_stream_if.sink   in_ch,
  mbss_stream_if.source out_ch,
  mbss_stream_if.sink   cfg_ch
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [7:0]           key_mask_r;
  logic                 v2_r;
  mbss_pkg::res_flags_t flags_r;
  mbss_pkg::res_flags_t flags;
  logic                 fire, down_ready;
  logic                 wr_en, rd_en;
  logic [PTR_W-1:0]     wr_addr, rd_addr;
  logic [7:0]           wr_data, rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r <= mbss_pkg::KEY_MASK_RST;
    end else if (cfg_ch.valid) begin
      key_mask_r <= cfg_ch.payload;
    end
  end

  assign down_ready = !v2_r || out_ch.ready;

  mbss_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .key_mask   (key_mask_r),
    .down_ready (down_ready),
    .fire       (fire),
    .flags      (flags),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  mbss_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (fire) begin
      v2_r <= 1'b1;
    end else if (out_ch.ready) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      flags_r <= flags;
    end
  end

  assign out_ch.valid                 = v2_r;
  assign out_ch.payload.slot_position = flags_r.slot;
  assign out_ch.payload.midi_present  = flags_r.present;
  // empty slot or non-slot word gives a zero byte
  assign out_ch.payload.midi_byte     = flags_r.present ? rd_data : 8'h00;
  assign out_ch.payload.overflow      = flags_r.overflow;

endmodule
